// ===== hw/rtl/csvtok_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Character codes, parser state and result types shared by the tokenizer.
// ----------------------------------------------------------------------------
package csvtok_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Most results that one input transfer can cause.
    localparam int MAX_RES = 3;

    // Parser flags carried from one character to the next.
    typedef struct packed {
        logic inside_quotes;
        logic quote_closed;
        logic field_has_text;
        logic quote_pending;
        logic return_pending;
        logic record_open;
        logic error_seen;
    } pstate_t;

    // One result item without the per-transfer malformed and last marks.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_field;
        logic       end_of_record;
    } res_t;

    // All results of one input item.
    typedef struct packed {
        res_t [MAX_RES-1:0] slot;
        logic [1:0]         cnt;
        logic               err;
    } bundle_t;

endpackage

// ===== hw/rtl/csv_record_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV record tokenizer
// Splits a CSV byte stream into field content bytes with field and record ends.
// ----------------------------------------------------------------------------
// The tokenizer takes one character per input transfer and returns between
// zero and three result transfers for it, in order. A character is held in an
// input register, and in the cycle in which the result buffer is free the
// parser flags and all of that character's results are updated in one step.
// Input transfers can therefore follow back to back while each character
// causes at most one result and the result stream is not stalled; one that
// causes more holds the single output port until its last result is taken,
// which is what sets the sustained rate. The input register and the result
// buffer register lie between an input transfer and its first result. A quote
// inside a quoted field or a carriage return gives its result only when the
// next character (or the end of stream) decides it. The malformed flag is
// sticky until reset and is shown on every result transfer.
module csv_record_tokenizer
    import csvtok_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
    input  logic        s_axis_tuser,  // [0] byte_present
    input  logic        s_axis_tlast,  // end_of_stream
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] end_of_field,
                                       // [9] end_of_record, [10] malformed,
                                       // [15:11] zero
    output logic        m_axis_tuser,  // [0] byte_valid
    output logic        m_axis_tlast   // last result of this input transfer
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_eos_reg;
    logic       advance;
    logic       free;
    bundle_t    bundle;
    res_t       out_res;
    logic       out_err;

    // The held character moves into the parser whenever the result buffer
    // has no results left after this cycle.
    assign advance       = in_valid_reg && free;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_present_reg <= s_axis_tuser;
            in_eos_reg     <= s_axis_tlast;
        end
    end

    csvtok_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_byte       (in_byte_reg),
        .byte_present  (in_present_reg),
        .end_of_stream (in_eos_reg),
        .bundle        (bundle)
    );

    csvtok_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .bundle    (bundle),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_err   (out_err),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_err, out_res.end_of_record,
                           out_res.end_of_field, out_res.out_byte};
    assign m_axis_tuser = out_res.byte_valid;

endmodule

// ===== hw/rtl/csvtok_step.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer step logic
// Holds the parser flags and works out the results of one input character.
// ----------------------------------------------------------------------------
module csvtok_step
    import csvtok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] in_byte,
    input  logic       byte_present,
    input  logic       end_of_stream,
    output bundle_t    bundle
);

    typedef struct packed {
        pstate_t st;
        logic    emit;
        res_t    res;
    } tb_t;

    pstate_t state_reg;
    pstate_t state_next;

    // Handles one character once no lookahead is pending.
    function automatic tb_t take_byte(pstate_t s, logic [7:0] c, logic cr_literal);
        tb_t r;
        r.st   = s;
        r.emit = 1'b0;
        r.res  = '0;
        r.st.record_open = 1'b1;
        if (s.inside_quotes)
        begin
            if (c == CH_QUOTE)
            begin
                r.st.quote_pending = 1'b1;
            end
            else if (c == CH_CR && !cr_literal)
            begin
                r.st.return_pending = 1'b1;
            end
            else
            begin
                r.emit           = 1'b1;
                r.res.out_byte   = c;
                r.res.byte_valid = 1'b1;
            end
        end
        else if (c == CH_COMMA || c == CH_LF)
        begin
            r.emit                = 1'b1;
            r.res.end_of_field    = 1'b1;
            r.res.end_of_record   = (c == CH_LF);
            r.st.field_has_text   = 1'b0;
            r.st.quote_closed     = 1'b0;
            if (c == CH_LF)
            begin
                r.st.record_open = 1'b0;
            end
        end
        else if (c == CH_CR && !cr_literal)
        begin
            r.st.return_pending = 1'b1;
        end
        else if (c == CH_QUOTE && !s.field_has_text && !s.quote_closed)
        begin
            r.st.inside_quotes = 1'b1;
        end
        else if (s.quote_closed || c == CH_QUOTE)
        begin
            // Stray quote or text after a closing quote: a status result only.
            r.st.error_seen = 1'b1;
            r.emit          = 1'b1;
        end
        else
        begin
            r.st.field_has_text = 1'b1;
            r.emit              = 1'b1;
            r.res.out_byte      = c;
            r.res.byte_valid    = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        pstate_t    s;
        tb_t        tb;
        res_t       r;
        logic [1:0] n;
        s           = state_reg;
        n           = 2'd0;
        bundle.slot = '0;
        tb          = '0;
        r           = '0;

        if (byte_present)
        begin
            if (s.quote_pending)
            begin
                s.quote_pending = 1'b0;
                if (in_byte == CH_QUOTE)
                begin
                    r            = '0;
                    r.out_byte   = CH_QUOTE;
                    r.byte_valid = 1'b1;
                    bundle.slot[n] = r;
                    n = n + 2'd1;
                end
                else
                begin
                    s.inside_quotes = 1'b0;
                    s.quote_closed  = 1'b1;
                    tb = take_byte(s, in_byte, 1'b0);
                    s  = tb.st;
                    if (tb.emit)
                    begin
                        bundle.slot[n] = tb.res;
                        n = n + 2'd1;
                    end
                end
            end
            else if (s.return_pending)
            begin
                s.return_pending = 1'b0;
                if (in_byte == CH_LF)
                begin
                    r = '0;
                    if (s.inside_quotes)
                    begin
                        r.out_byte   = CH_LF;
                        r.byte_valid = 1'b1;
                    end
                    else
                    begin
                        r.end_of_field   = 1'b1;
                        r.end_of_record  = 1'b1;
                        s.field_has_text = 1'b0;
                        s.quote_closed   = 1'b0;
                        s.record_open    = 1'b0;
                    end
                    bundle.slot[n] = r;
                    n = n + 2'd1;
                end
                else
                begin
                    // The held carriage return counts as an ordinary character.
                    tb = take_byte(s, CH_CR, 1'b1);
                    s  = tb.st;
                    if (tb.emit)
                    begin
                        bundle.slot[n] = tb.res;
                        n = n + 2'd1;
                    end
                    tb = take_byte(s, in_byte, 1'b0);
                    s  = tb.st;
                    if (tb.emit)
                    begin
                        bundle.slot[n] = tb.res;
                        n = n + 2'd1;
                    end
                end
            end
            else
            begin
                tb = take_byte(s, in_byte, 1'b0);
                s  = tb.st;
                if (tb.emit)
                begin
                    bundle.slot[n] = tb.res;
                    n = n + 2'd1;
                end
            end
        end

        if (end_of_stream)
        begin
            if (s.quote_pending)
            begin
                s.quote_pending = 1'b0;
                s.inside_quotes = 1'b0;
                s.quote_closed  = 1'b1;
            end
            s.return_pending = 1'b0;
            if (s.inside_quotes)
            begin
                s.error_seen = 1'b1;
            end
            if (s.record_open)
            begin
                r               = '0;
                r.end_of_field  = 1'b1;
                r.end_of_record = 1'b1;
                bundle.slot[n]  = r;
                n = n + 2'd1;
            end
            s.inside_quotes  = 1'b0;
            s.quote_closed   = 1'b0;
            s.field_has_text = 1'b0;
            s.record_open    = 1'b0;
        end

        bundle.cnt = n;
        bundle.err = s.error_seen;
        state_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/csvtok_obuf.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer result buffer
// Holds the results of one character and hands them out one per transfer.
// ----------------------------------------------------------------------------
module csvtok_obuf
    import csvtok_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output res_t    out_res,
    output logic    out_err,
    output logic    out_last
);

    bundle_t    bundle_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       take;

    assign out_valid = (idx_reg != cnt_reg);
    assign out_last  = (idx_reg == cnt_reg - 2'd1);
    assign take      = out_valid && out_ready;
    assign free      = !out_valid || (take && out_last);
    assign out_res   = bundle_reg.slot[idx_reg];
    assign out_err   = bundle_reg.err;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = bundle.cnt;
            idx_next = 2'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

// ===== hw/rtl/csvtok_chk.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer port checker
// Watches the result stream of the tokenizer for inconsistent marks.
// ----------------------------------------------------------------------------
module csvtok_chk
    import csvtok_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic out_xfer;
    logic err_seen_reg;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else if (out_xfer && m_axis_tdata[10])
        begin
            err_seen_reg <= 1'b1;
        end
    end

    // Once a transfer reported malformed input, every later one does too.
    a_sticky_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && err_seen_reg |-> m_axis_tdata[10])
        else $error("malformed flag dropped");

    // A content byte never carries a field or record end.
    a_content_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[8] && !m_axis_tdata[9])
        else $error("content byte with end mark");

    // A record end always closes the last field as well.
    a_record_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
        else $error("record end without field end");

    // A result that is not content carries a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("nonzero byte on a mark result");

    // A stalled result stays offered unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind csv_record_tokenizer csvtok_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
